FILE: rtl/contact_shear_rotate_increment_defines.svh
// Assertion macros used by the top-level RTL.
`ifndef CONTACT_SHEAR_ROTATE_INCREMENT_DEFINES_SVH
`define CONTACT_SHEAR_ROTATE_INCREMENT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked out of reset only
`define CSRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset as well
`define CSRI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CSRI_ASSERT(lbl, prop, msg)
`define CSRI_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: rtl/csri_pkg.sv
package csri_pkg;

  localparam int DEF_COMPONENT_BITS = 21;
  localparam int VEC_BITS           = 63;
  localparam int RAD_BITS           = 42;
  localparam int DT_BITS            = 24;
  localparam int DT_HALF            = DT_BITS / 2;
  localparam int CFG_IDX_BITS       = 1;
  localparam int CFG_DATA_BITS      = 24;
  localparam int PIPE_DEPTH         = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TIME_STEP   = 1'b0,
    CFG_BRANCH_MODE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [VEC_BITS-1:0] shear_force;
    logic [VEC_BITS-1:0] previous_normal;
    logic [VEC_BITS-1:0] contact_normal;
    logic [VEC_BITS-1:0] contact_point;
    logic [VEC_BITS-1:0] position_a;
    logic [VEC_BITS-1:0] position_b;
    logic [VEC_BITS-1:0] velocity_a;
    logic [VEC_BITS-1:0] velocity_b;
    logic [VEC_BITS-1:0] spin_a;
    logic [VEC_BITS-1:0] spin_b;
    logic [VEC_BITS-1:0] shift_velocity;
    logic [RAD_BITS-1:0] radii;
  } in_t;

  typedef struct packed {
    logic [VEC_BITS-1:0] rotated_shear_force;
    logic [VEC_BITS-1:0] shear_displacement;
  } out_t;

endpackage

FILE: rtl/csri_rot.sv
module csri_rot #(
  parameter int C = csri_pkg::DEF_COMPONENT_BITS
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  csri_pkg::in_t                 in_i,
  input  logic [csri_pkg::DT_BITS-1:0]  dt_i,
  output logic [csri_pkg::VEC_BITS-1:0] rot_o
);
  import csri_pkg::*;

  localparam int F   = C - 5;
  localparam int SW  = 2 * C + 40;
  localparam int DWW = C + 9;
  localparam int AW  = DWW + DT_BITS + 1;
  localparam logic signed [SW-1:0] ONE  = 1;
  localparam logic signed [SW-1:0] SMAX = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  typedef logic signed [C-1:0]   comp_t;
  typedef logic signed [2*C-1:0] prod_t;

  function automatic comp_t sat(input logic signed [SW-1:0] v);
    comp_t r;
    if (v > SMAX)      r = SMAX[C-1:0];
    else if (v < SMIN) r = SMIN[C-1:0];
    else               r = v[C-1:0];
    return r;
  endfunction

  function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v, input int s);
    return (v + (ONE <<< (s - 1))) >>> s;
  endfunction

  comp_t f_s [3];
  comp_t np_s [3];
  comp_t n_s [3];
  logic signed [C:0] ws_s [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_s[i]  = $signed(in_i.shear_force[i*C +: C]);
      np_s[i] = $signed(in_i.previous_normal[i*C +: C]);
      n_s[i]  = $signed(in_i.contact_normal[i*C +: C]);
      ws_s[i] = (C+1)'($signed(in_i.spin_a[i*C +: C]))
              + (C+1)'($signed(in_i.spin_b[i*C +: C]));
    end
  end

  // stage registers
  prod_t pax_q [3], pbx_q [3];
  logic signed [2*C+1:0] pdw_q [3];
  comp_t f1s_q [3], n1_q [3];
  comp_t axis_q [3], f2s_q [3], n2_q [3];
  logic signed [DWW-1:0] dotw_q;
  prod_t pfa_q [3], pfb_q [3];
  logic signed [AW-1:0] pang_q;
  comp_t f3s_q [3], n3_q [3];
  comp_t f1_q [3], n4_q [3];
  comp_t ang_q;
  prod_t ptw_q [3];
  comp_t f15_q [3];
  comp_t tw_q [3], f16_q [3];
  prod_t pta_q [3], ptb_q [3];
  comp_t f17_q [3];
  comp_t f2_q [3], d9_q [3], d10_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        // normal change: np x n
        pax_q[i] <= np_s[(i+1)%3] * n_s[(i+2)%3];
        pbx_q[i] <= np_s[(i+2)%3] * n_s[(i+1)%3];
        pdw_q[i] <= (2*C+2)'(n_s[i]) * (2*C+2)'(ws_s[i]);
        f1s_q[i] <= f_s[i];
        n1_q[i]  <= n_s[i];

        axis_q[i] <= sat(rnd(SW'(pax_q[i]) - SW'(pbx_q[i]), F));
        f2s_q[i]  <= f1s_q[i];
        n2_q[i]   <= n1_q[i];

        pfa_q[i] <= f2s_q[(i+1)%3] * axis_q[(i+2)%3];
        pfb_q[i] <= f2s_q[(i+2)%3] * axis_q[(i+1)%3];
        f3s_q[i] <= f2s_q[i];
        n3_q[i]  <= n2_q[i];

        f1_q[i] <= sat(SW'(f3s_q[i]) - rnd(SW'(pfa_q[i]) - SW'(pfb_q[i]), F));
        n4_q[i] <= n3_q[i];

        ptw_q[i] <= ang_q * n4_q[i];
        f15_q[i] <= f1_q[i];

        tw_q[i]  <= sat(rnd(SW'(ptw_q[i]), F));
        f16_q[i] <= f15_q[i];

        pta_q[i] <= f16_q[(i+1)%3] * tw_q[(i+2)%3];
        ptb_q[i] <= f16_q[(i+2)%3] * tw_q[(i+1)%3];
        f17_q[i] <= f16_q[i];

        f2_q[i]  <= sat(SW'(f17_q[i]) - rnd(SW'(pta_q[i]) - SW'(ptb_q[i]), F));
        d9_q[i]  <= f2_q[i];
        d10_q[i] <= d9_q[i];
      end
      dotw_q <= DWW'(rnd(SW'(pdw_q[0]) + SW'(pdw_q[1]) + SW'(pdw_q[2]), F));
      pang_q <= AW'(dotw_q) * AW'($signed({1'b0, dt_i}));
      // dt/2 folded into the shift
      ang_q  <= sat(rnd(SW'(pang_q), DT_BITS + 1));
    end
  end

  assign rot_o = VEC_BITS'({d10_q[2], d10_q[1], d10_q[0]});

endmodule

FILE: rtl/csri_disp.sv
module csri_disp #(
  parameter int C = csri_pkg::DEF_COMPONENT_BITS
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  csri_pkg::in_t                 in_i,
  input  logic [csri_pkg::DT_BITS-1:0]  dt_i,
  input  logic                          mode_i,
  output logic [csri_pkg::VEC_BITS-1:0] disp_o
);
  import csri_pkg::*;

  localparam int F   = C - 5;
  localparam int SW  = 2 * C + 40;
  localparam int XW  = C + 7;
  localparam int RW  = C + 10;
  localparam int DNW = C + 18;
  localparam int TW  = C + 25;
  localparam int HW  = TW + DT_HALF + 1;
  localparam logic signed [SW-1:0] ONE  = 1;
  localparam logic signed [SW-1:0] SMAX = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  typedef logic signed [C-1:0]   comp_t;
  typedef logic signed [C:0]     br_t;
  typedef logic signed [2*C:0]   prod_t;

  function automatic comp_t sat(input logic signed [SW-1:0] v);
    comp_t r;
    if (v > SMAX)      r = SMAX[C-1:0];
    else if (v < SMIN) r = SMIN[C-1:0];
    else               r = v[C-1:0];
    return r;
  endfunction

  function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v, input int s);
    return (v + (ONE <<< (s - 1))) >>> s;
  endfunction

  comp_t n_s [3], x_s [3], pa_s [3], pb_s [3];
  comp_t va_s [3], vb_s [3], wa_s [3], wb_s [3], sh_s [3];
  br_t ra_s, rb_s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_s[i]  = $signed(in_i.contact_normal[i*C +: C]);
      x_s[i]  = $signed(in_i.contact_point[i*C +: C]);
      pa_s[i] = $signed(in_i.position_a[i*C +: C]);
      pb_s[i] = $signed(in_i.position_b[i*C +: C]);
      va_s[i] = $signed(in_i.velocity_a[i*C +: C]);
      vb_s[i] = $signed(in_i.velocity_b[i*C +: C]);
      wa_s[i] = $signed(in_i.spin_a[i*C +: C]);
      wb_s[i] = $signed(in_i.spin_b[i*C +: C]);
      sh_s[i] = $signed(in_i.shift_velocity[i*C +: C]);
    end
    ra_s = $signed({1'b0, in_i.radii[C-1:0]});
    rb_s = $signed({1'b0, in_i.radii[2*C-1:C]});
  end

  prod_t pca_q [3], pcb_q [3];
  comp_t ca0_q [3], cb0_q [3];
  comp_t n1_q [3], va1_q [3], vb1_q [3], wa1_q [3], wb1_q [3], sh1_q [3];
  br_t ca_q [3], cb_q [3];
  comp_t n2_q [3], va2_q [3], vb2_q [3], wa2_q [3], wb2_q [3], sh2_q [3];
  prod_t pxa_q [3], pxb_q [3], pya_q [3], pyb_q [3];
  comp_t n3_q [3], va3_q [3], vb3_q [3], sh3_q [3];
  logic signed [RW-1:0] rel_q [3], rel5_q [3], rel6_q [3], rel7_q [3];
  comp_t n4_q [3], n5_q [3], n6_q [3];
  logic signed [C+RW-1:0] pnr_q [3];
  logic signed [DNW-1:0] dn_q;
  logic signed [DNW+C-1:0] pdn_q [3];
  logic signed [TW-1:0] tan_q [3];
  logic signed [HW-1:0] plo_q [3], phi_q [3];
  comp_t disp_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        // branch vectors, both forms
        pca_q[i] <= (2*C+1)'(ra_s) * (2*C+1)'(n_s[i]);
        pcb_q[i] <= (2*C+1)'(rb_s) * (2*C+1)'(n_s[i]);
        ca0_q[i] <= sat(SW'(x_s[i]) - SW'(pa_s[i]));
        cb0_q[i] <= sat(SW'(x_s[i]) - SW'(pb_s[i]));
        n1_q[i]  <= n_s[i];
        va1_q[i] <= va_s[i];
        vb1_q[i] <= vb_s[i];
        wa1_q[i] <= wa_s[i];
        wb1_q[i] <= wb_s[i];
        sh1_q[i] <= sh_s[i];

        ca_q[i] <= mode_i ? (C+1)'(sat(rnd(SW'(pca_q[i]), F))) : (C+1)'(ca0_q[i]);
        cb_q[i] <= mode_i ? -((C+1)'(sat(rnd(SW'(pcb_q[i]), F)))) : (C+1)'(cb0_q[i]);
        n2_q[i]  <= n1_q[i];
        va2_q[i] <= va1_q[i];
        vb2_q[i] <= vb1_q[i];
        wa2_q[i] <= wa1_q[i];
        wb2_q[i] <= wb1_q[i];
        sh2_q[i] <= sh1_q[i];

        pxa_q[i] <= (2*C+1)'(wa2_q[(i+1)%3]) * (2*C+1)'(ca_q[(i+2)%3]);
        pxb_q[i] <= (2*C+1)'(wa2_q[(i+2)%3]) * (2*C+1)'(ca_q[(i+1)%3]);
        pya_q[i] <= (2*C+1)'(wb2_q[(i+1)%3]) * (2*C+1)'(cb_q[(i+2)%3]);
        pyb_q[i] <= (2*C+1)'(wb2_q[(i+2)%3]) * (2*C+1)'(cb_q[(i+1)%3]);
        n3_q[i]  <= n2_q[i];
        va3_q[i] <= va2_q[i];
        vb3_q[i] <= vb2_q[i];
        sh3_q[i] <= sh2_q[i];

        rel_q[i] <= RW'((SW'(vb3_q[i]) + rnd(SW'(pya_q[i]) - SW'(pyb_q[i]), F))
                      - (SW'(va3_q[i]) + rnd(SW'(pxa_q[i]) - SW'(pxb_q[i]), F))
                      + SW'(sh3_q[i]));
        n4_q[i]  <= n3_q[i];

        pnr_q[i]  <= (C+RW)'(n4_q[i]) * (C+RW)'(rel_q[i]);
        rel5_q[i] <= rel_q[i];
        n5_q[i]   <= n4_q[i];

        rel6_q[i] <= rel5_q[i];
        n6_q[i]   <= n5_q[i];

        pdn_q[i]  <= (DNW+C)'(dn_q) * (DNW+C)'(n6_q[i]);
        rel7_q[i] <= rel6_q[i];

        tan_q[i] <= TW'(SW'(rel7_q[i]) - rnd(SW'(pdn_q[i]), F));

        // dt split in halves to keep each multiplier narrow
        plo_q[i] <= HW'(tan_q[i]) * HW'($signed({1'b0, dt_i[DT_HALF-1:0]}));
        phi_q[i] <= HW'(tan_q[i]) * HW'($signed({1'b0, dt_i[DT_BITS-1:DT_HALF]}));

        disp_q[i] <= sat(rnd((SW'(phi_q[i]) <<< DT_HALF) + SW'(plo_q[i]), DT_BITS));
      end
      dn_q <= DNW'(rnd(SW'(pnr_q[0]) + SW'(pnr_q[1]) + SW'(pnr_q[2]), F));
    end
  end

  assign disp_o = VEC_BITS'({disp_q[2], disp_q[1], disp_q[0]});

endmodule

FILE: rtl/contact_shear_rotate_increment.sv
// Contact shear rotation and displacement increment, one sphere contact per transaction.
// Input channel: valid_i / stall_o with in_i carrying all contact vectors and radii.
// Output channel: valid_o / stall_i with out_o carrying the rotated shear force and
// the tangential shear displacement over the time step.
// Configuration: cfg_we_i writes cfg_data_i into the register chosen by cfg_idx_i
// (time step, branch mode); write only while no transaction is in flight.
// The datapath has ten register stages (four chained multiplies on the displacement
// path, each followed by a rounding/saturation stage, plus the split dt multiply).
// Throughput: one transaction per cycle while the output is not stalled.
// When stall_i is high with valid_o set, the whole pipeline holds and stall_o is
// raised; nothing is dropped or repeated, and empty slots are not squeezed out.
// Reset clears the valid bits and sets the time step and branch mode to zero.
`include "contact_shear_rotate_increment_defines.svh"

module contact_shear_rotate_increment #(
  parameter int COMPONENT_BITS = csri_pkg::DEF_COMPONENT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  csri_pkg::in_t                       in_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output csri_pkg::out_t                      out_o,
  input  logic                                cfg_we_i,
  input  logic [csri_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [csri_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import csri_pkg::*;

  logic [DT_BITS-1:0]    dt_q;
  logic                  mode_q;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  en;
  logic [VEC_BITS-1:0]   rot;
  logic [VEC_BITS-1:0]   disp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= '0;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIME_STEP:   dt_q   <= cfg_data_i[DT_BITS-1:0];
        CFG_BRANCH_MODE: mode_q <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  assign en      = !(vld_q[PIPE_DEPTH-1] && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], valid_i};
    end
  end

  csri_rot #(.C(COMPONENT_BITS)) u_rot (
    .clk_i (clk_i),
    .en_i  (en),
    .in_i  (in_i),
    .dt_i  (dt_q),
    .rot_o (rot)
  );

  csri_disp #(.C(COMPONENT_BITS)) u_disp (
    .clk_i  (clk_i),
    .en_i   (en),
    .in_i   (in_i),
    .dt_i   (dt_q),
    .mode_i (mode_q),
    .disp_o (disp)
  );

  assign valid_o                   = vld_q[PIPE_DEPTH-1];
  assign out_o.rotated_shear_force = rot;
  assign out_o.shear_displacement  = disp;

  `CSRI_ASSERT(a_accept_enters, valid_i && !stall_o |=> vld_q[0], "accepted transaction lost")
  `CSRI_ASSERT(a_hold_on_stall, stall_o |=> $stable(vld_q), "pipeline moved while stalled")
  `CSRI_ASSERT(a_stall_cause, stall_o |-> valid_o, "stall raised with empty output stage")
  `CSRI_ASSERT_RST(a_reset_empty, !rst_ni |-> !valid_o, "output valid during reset")

endmodule
